### sv/dpst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpst_pkg
// Shared types and constants of the dense Prim spanning tree block.
// ---------------------------------------------------------------------------
package dpst_pkg;

  localparam int DEF_MAX_NODES   = 256;
  localparam int DEF_LENGTH_BITS = 24;
  localparam int EPOCH_BITS      = 8;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 32;
  localparam int NODE_BITS       = 8;
  localparam int EDGE_LEN_BITS   = 24;
  localparam int TREE_LEN_BITS   = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CABLE_BUDGET = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } dpst_state_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic start;
    logic issue;
    logic round;
    logic emit;
  } dpst_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic any_left;
    logic found;
    logic out_free;
    logic epoch_wrap;
  } dpst_sts_t;

endpackage

### sv/dpst_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpst_in_if / dpst_out_if
// Valid/ready channels for edge and solve items and for solve results.
// ---------------------------------------------------------------------------
interface dpst_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  node_a;
  logic [7:0]  node_b;
  logic [23:0] edge_length;

  modport source (output valid, operation, node_a, node_b, edge_length, input ready);
  modport sink (input valid, operation, node_a, node_b, edge_length, output ready);
endinterface

interface dpst_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] tree_length;
  logic        connected;
  logic        fits_budget;

  modport source (output valid, tree_length, connected, fits_budget, input ready);
  modport sink (input valid, tree_length, connected, fits_budget, output ready);
endinterface

### sv/dpst_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpst_ram
// Generic single-write, single-read RAM with a registered read.
// ---------------------------------------------------------------------------
module dpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/dpst_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpst_ctrl
// Sequencer for loads, the Prim scan rounds, result output and store clearing.
// ---------------------------------------------------------------------------
module dpst_ctrl import dpst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_rdy,
  input  dpst_sts_t sts,
  output dpst_cmd_t cmd
);

  dpst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_op == OP_SOLVE) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_ROUND;
      ST_ROUND: begin
        state_nxt = (sts.any_left && sts.found) ? ST_SCAN : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = sts.epoch_wrap ? ST_CLEAR : ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd    = '0;
    in_rdy = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_rdy    = 1'b1;
        cmd.load  = in_valid && in_op == OP_LOAD;
        cmd.start = in_valid && in_op == OP_SOLVE;
      end
      ST_SCAN:  cmd.issue = 1'b1;
      ST_DRAIN: cmd       = '0;
      ST_ROUND: cmd.round = 1'b1;
      ST_EMIT:  cmd.emit  = sts.out_free;
      default:  cmd       = '0;
    endcase
  end

endmodule

### sv/dpst_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpst_dp
// Datapath: edge store, tentative costs, minimum search and tree total.
// ---------------------------------------------------------------------------
module dpst_dp import dpst_pkg::*; #(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dpst_cmd_t                cmd,
  output dpst_sts_t                sts,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic [NODE_BITS-1:0]     node_a,
  input  logic [NODE_BITS-1:0]     node_b,
  input  logic [EDGE_LEN_BITS-1:0] edge_length,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TREE_LEN_BITS-1:0] tree_length,
  output logic                     connected,
  output logic                     fits_budget
);

  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int AW    = 2 * NW;
  localparam int EDEP  = 1 << AW;
  localparam int EW    = EPOCH_BITS + LENGTH_BITS;
  localparam int TW    = LENGTH_BITS + NW;
  localparam int SUMW  = (TW > TREE_LEN_BITS + 1) ? TW : TREE_LEN_BITS + 1;

  logic [8:0]               node_count_r;
  logic [CFG_DATA_BITS-1:0] budget_r;
  logic [EPOCH_BITS-1:0]    epoch_r;
  logic [AW-1:0]            clr_addr_r;
  logic [CW-1:0]            cnt_r;
  logic [NW-1:0]            pick_r, u_r, u_p_r;
  logic                     rd_v_r;
  logic [MAX_NODES-1:0]     in_tree_r, valid_r;
  logic                     any_left_r, found_r, whole_r;
  logic [LENGTH_BITS-1:0]   min_r;
  logic [NW-1:0]            min_idx_r;
  logic [SUMW-1:0]          total_r;
  logic                     out_valid_r;
  logic [TREE_LEN_BITS-1:0] tree_length_r;
  logic                     connected_r, fits_r;

  logic [NW-1:0]            la, lb, lo, hi;
  logic                     ld_ok;
  logic                     e_we;
  logic [AW-1:0]            e_waddr, e_raddr;
  logic [EW-1:0]            e_wdata, e_rdata;
  logic [LENGTH_BITS-1:0]   c_rdata, e_len, ncost;
  logic                     left, present, upd, nvalid, better;
  logic [CW-1:0]            cnt_nxt;
  logic [EPOCH_BITS-1:0]    epoch_inc;

  assign la    = NW'(node_a);
  assign lb    = NW'(node_b);
  assign ld_ok = (32'(node_a) < MAX_NODES) && (32'(node_b) < MAX_NODES);
  assign lo    = (pick_r < u_r) ? pick_r : u_r;
  assign hi    = (pick_r < u_r) ? u_r : pick_r;

  always_comb begin
    e_we    = 1'b0;
    e_waddr = clr_addr_r;
    e_wdata = '0;
    if (cmd.clear_wr) begin
      e_we = 1'b1;
    end else if (cmd.load && ld_ok) begin
      e_we    = 1'b1;
      e_waddr = (la < lb) ? {la, lb} : {lb, la};
      e_wdata = {epoch_r, LENGTH_BITS'(edge_length)};
    end
  end

  assign e_raddr = {lo, hi};

  dpst_ram #(.WIDTH(EW), .DEPTH(EDEP)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  dpst_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_NODES)) u_cost_ram (
    .clk   (clk),
    .we    (upd),
    .waddr (u_p_r),
    .wdata (e_len),
    .raddr (u_r),
    .rdata (c_rdata)
  );

  assign e_len   = e_rdata[LENGTH_BITS-1:0];
  assign present = e_rdata[EW-1:LENGTH_BITS] == epoch_r;
  assign left    = rd_v_r && !in_tree_r[u_p_r];
  assign upd     = left && present && (!valid_r[u_p_r] || e_len < c_rdata);
  assign ncost   = upd ? e_len : c_rdata;
  assign nvalid  = valid_r[u_p_r] || upd;
  assign better  = left && nvalid && (!found_r || ncost < min_r);

  always_comb begin
    if (node_count_r == '0) begin
      cnt_nxt = CW'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      cnt_nxt = CW'(MAX_NODES);
    end else begin
      cnt_nxt = CW'(node_count_r);
    end
  end

  assign epoch_inc = epoch_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 9'd1;
      budget_r     <= '0;
      epoch_r      <= EPOCH_BITS'(1);
      clr_addr_r   <= '0;
      rd_v_r       <= 1'b0;
      in_tree_r    <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      total_r      <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_NODE_COUNT) node_count_r <= cfg_wdata[8:0];
      if (cfg_we && cfg_index == CFG_CABLE_BUDGET) budget_r <= cfg_wdata;
      if (cmd.clear_wr) clr_addr_r <= clr_addr_r + 1'b1;
      rd_v_r <= cmd.issue;
      if (upd) valid_r[u_p_r] <= 1'b1;
      if (cmd.start) begin
        in_tree_r    <= MAX_NODES'(1);
        valid_r      <= '0;
        total_r      <= '0;
      end
      if (cmd.round && found_r && any_left_r) begin
        in_tree_r[min_idx_r] <= 1'b1;
        total_r <= total_r + SUMW'(min_r);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        epoch_r     <= (epoch_inc == '0) ? EPOCH_BITS'(1) : epoch_inc;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    u_p_r <= u_r;
    if (cmd.start) begin
      cnt_r      <= cnt_nxt;
      pick_r     <= '0;
      u_r        <= '0;
      any_left_r <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.round) begin
      whole_r    <= !any_left_r;
      pick_r     <= min_idx_r;
      u_r        <= '0;
      any_left_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (cmd.issue) u_r <= u_r + 1'b1;
      if (left) any_left_r <= 1'b1;
      if (better) begin
        found_r   <= 1'b1;
        min_r     <= ncost;
        min_idx_r <= u_p_r;
      end
    end
    if (cmd.emit) begin
      tree_length_r <= (total_r[SUMW-1:TREE_LEN_BITS] != '0) ? '1
                                                             : total_r[TREE_LEN_BITS-1:0];
      connected_r   <= whole_r;
      fits_r        <= whole_r && (total_r <= SUMW'(budget_r));
    end
  end

  assign sts.clear_last = &clr_addr_r;
  assign sts.scan_last  = (CW'(u_r) + 1'b1) == cnt_r;
  assign sts.any_left   = any_left_r;
  assign sts.found      = found_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.epoch_wrap = epoch_inc == '0;

  assign out_valid   = out_valid_r;
  assign tree_length = tree_length_r;
  assign connected   = connected_r;
  assign fits_budget = fits_r;

endmodule

### sv/dense_prim_spanning_tree.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dense_prim_spanning_tree
// Minimum spanning tree of a dense graph by Prim's algorithm, budget check.
// ---------------------------------------------------------------------------
// Items arrive on in_ch. A load transaction stores one undirected edge; a
// later edge between the same pair replaces the earlier. A solve
// transaction runs Prim's algorithm from node 0 over node_count nodes and
// returns one transaction on out_ch with the tree length, a connected flag
// and the budget flag. A solve runs in rounds, at most N of them, N being
// the node count; each round scans the edge RAM through its single read
// port, one entry per cycle. The edge store is emptied after each solve by
// advancing an epoch tag; on every 255th solve the tag wraps and a clearing
// pass over all edge RAM entries (65536 by default) runs. The same pass
// runs after reset, during which in_ch is not ready; cfg writes are taken
// at any time. The result sits in an output register, so loads are
// accepted while it waits; a stalled receiver holds only the end of the
// next solve.
// ---------------------------------------------------------------------------
module dense_prim_spanning_tree import dpst_pkg::*; #(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  dpst_in_if.sink                  in_ch,
  dpst_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  dpst_cmd_t cmd;
  dpst_sts_t sts;

  dpst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_rdy   (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpst_dp #(.MAX_NODES(MAX_NODES), .LENGTH_BITS(LENGTH_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .node_a      (in_ch.node_a),
    .node_b      (in_ch.node_b),
    .edge_length (in_ch.edge_length),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .tree_length (out_ch.tree_length),
    .connected   (out_ch.connected),
    .fits_budget (out_ch.fits_budget)
  );

endmodule
